>>> hdl/dcfp_pkg.sv
// shared types and constants of the drive command frame parser
`default_nettype none
package dcfp_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'hAA;
	localparam logic [2:0] CHECK_POS   = 3'd5;
	localparam logic [2:0] FIRST_POS   = 3'd1;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef logic [7:0]         byte_t;
	typedef logic signed [15:0] field_t;
	typedef logic signed [16:0] target_t;

	// decoded frame handed from front to back
	typedef struct packed {
		field_t speed;
		field_t turn;
	} frame_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

>>> hdl/dcfp_if.sv
// valid/ready channels for received bytes and wheel targets
`default_nettype none
interface dcfp_byte_if;
	import dcfp_pkg::*;
	logic  valid;
	logic  ready;
	byte_t rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface dcfp_target_if;
	import dcfp_pkg::*;
	logic    valid;
	logic    ready;
	target_t left_target;
	target_t right_target;
	field_t  forward_speed;
	field_t  turn_rate;
	modport source (output valid, output left_target, output right_target,
		output forward_speed, output turn_rate, input ready);
	modport sink (input valid, input left_target, input right_target,
		input forward_speed, input turn_rate, output ready);
endinterface
`default_nettype wire

>>> hdl/dcfp_front.sv
// front end: header hunt, payload capture and checksum test
`default_nettype none
module dcfp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	dcfp_byte_if.sink            rx,
	input  wire dcfp_pkg::q_stat_t q_stat,
	output logic                 push,
	output dcfp_pkg::frame_t     push_frame
);
	import dcfp_pkg::*;

	logic       in_frame_q;
	logic [2:0] pos_q;
	byte_t      sum_q;
	byte_t      payload_q [4];
	logic       accept;
	logic       at_check;
	logic [1:0] slot;

	// a beat is taken whenever the queue has room
	assign rx.ready = !q_stat.full;
	assign accept   = rx.valid && rx.ready;
	assign at_check = (pos_q >= CHECK_POS);
	assign slot     = (pos_q == 3'd0) ? 2'd0 : 2'(pos_q - 3'd1);

	// good checksum hands the decoded frame on
	assign push = accept && in_frame_q && at_check && (rx.rx_byte == sum_q);
	assign push_frame.speed = field_t'({payload_q[1], payload_q[0]});
	assign push_frame.turn  = field_t'({payload_q[3], payload_q[2]});

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= 3'd0;
			sum_q      <= '0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (rx.rx_byte == HEADER_BYTE) begin
					in_frame_q <= 1'b1;
					pos_q      <= FIRST_POS;
					sum_q      <= HEADER_BYTE;
				end
			end else if (!at_check) begin
				sum_q <= sum_q + rx.rx_byte;
				pos_q <= 3'({1'b0, slot} + 3'd2);
			end else begin
				in_frame_q <= 1'b0;
				pos_q      <= 3'd0;
				sum_q      <= '0;
			end
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (accept && in_frame_q && !at_check) begin
			payload_q[slot] <= rx.rx_byte;
		end
	end

endmodule
`default_nettype wire

>>> hdl/dcfp_queue.sv
// short queue of decoded frames between front and back
`default_nettype none
module dcfp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire dcfp_pkg::frame_t  push_frame,
	input  wire logic              pop,
	output dcfp_pkg::frame_t       pop_frame,
	output dcfp_pkg::q_stat_t      q_stat
);
	import dcfp_pkg::*;

	localparam logic [QUEUE_AW:0] DEPTH_C = (QUEUE_AW + 1)'(QUEUE_DEPTH);

	frame_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign q_stat.full  = (count_q == DEPTH_C);
	assign q_stat.empty = (count_q == '0);
	assign pop_frame    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_frame;
	end

endmodule
`default_nettype wire

>>> hdl/dcfp_back.sv
// back end: wheel target sums into the output register
`default_nettype none
module dcfp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dcfp_pkg::q_stat_t q_stat,
	input  wire dcfp_pkg::frame_t  pop_frame,
	output logic                   pop,
	dcfp_target_if.source          tx
);
	import dcfp_pkg::*;

	logic    valid_q;
	target_t left_q;
	target_t right_q;
	field_t  speed_q;
	field_t  turn_q;
	target_t speed_x;
	target_t turn_x;

	// load when the output register is free or being emptied
	assign pop     = !q_stat.empty && (!valid_q || tx.ready);
	assign speed_x = target_t'(pop_frame.speed);
	assign turn_x  = target_t'(pop_frame.turn);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (tx.ready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			left_q  <= speed_x + turn_x;
			right_q <= turn_x - speed_x;
			speed_q <= pop_frame.speed;
			turn_q  <= pop_frame.turn;
		end
	end

	assign tx.valid         = valid_q;
	assign tx.left_target   = left_q;
	assign tx.right_target  = right_q;
	assign tx.forward_speed = speed_q;
	assign tx.turn_rate     = turn_q;

endmodule
`default_nettype wire

>>> hdl/drive_command_frame_parser_top.sv
// Drive command frame parser, top level.
// rx: one received serial byte per beat (valid/ready). The parser hunts for
// header 0xAA, then takes four payload bytes and a checksum byte equal to
// the 8-bit sum of header and payload. A matching frame yields one beat on
// tx: left_target = speed + turn, right_target = turn - speed (17 bits,
// no saturation), plus the decoded little-endian speed and turn.
// A bad checksum drops the frame with no beat; the parser hunts again.
// Throughput: one byte per cycle. The front takes bytes while a two-entry
// frame queue has room; the back moves a frame into the output register.
// A good frame is written into the queue as its checksum beat is taken and
// is then loaded into the output register, which sets tx valid, once free.
// When tx stalls, the output register holds and the queue fills; with the
// queue full rx.ready drops until the back drains an entry.
// Reset (arst_n low) returns to hunting and empties queue and output.
`default_nettype none
module drive_command_frame_parser_top (
	input  wire logic     clk,
	input  wire logic     arst_n,
	dcfp_byte_if.sink     rx,
	dcfp_target_if.source tx
);
	import dcfp_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	frame_t  push_frame;
	frame_t  pop_frame;

	dcfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.q_stat     (q_stat),
		.push       (push),
		.push_frame (push_frame)
	);

	dcfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.pop_frame  (pop_frame),
		.q_stat     (q_stat)
	);

	dcfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_frame (pop_frame),
		.pop       (pop),
		.tx        (tx)
	);

`ifndef NO_ASSERTIONS
	// no frame written into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full) else $error("frame pushed into full queue");

	// no frame read from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty) else $error("frame popped from empty queue");

	// left target agrees with the decoded fields
	a_left_sum: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> (tx.left_target ==
			(target_t'(tx.forward_speed) + target_t'(tx.turn_rate))))
		else $error("left target mismatch");

	// right target agrees with the decoded fields
	a_right_diff: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> (tx.right_target ==
			(target_t'(tx.turn_rate) - target_t'(tx.forward_speed))))
		else $error("right target mismatch");
`endif

endmodule
`default_nettype wire

>>> test/drive_command_frame_parser_top_test.sv
// self-checking testbench of the drive command frame parser
`timescale 1ns / 100ps
`default_nettype none
module drive_command_frame_parser_top_test;
	import dcfp_pkg::*;

	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned FRAME_BYTE_TARGET = 950;
	localparam int unsigned HOLD_CYCLES = 300;

	// one byte waiting for the driver, optionally held back until all targets are in
	typedef struct packed {
		logic  drain;
		byte_t data;
	} rx_item_t;

	// wheel targets of one good frame
	typedef struct packed {
		target_t left;
		target_t right;
		field_t  speed;
		field_t  turn;
	} wheel_t;

	logic clk;
	logic arst_n;

	dcfp_byte_if   rx_ch ();
	dcfp_target_if tx_ch ();

	drive_command_frame_parser_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	rx_item_t byte_q [$];
	wheel_t   target_q [$];

	// parser shadow state
	logic       in_frame = 1'b0;
	logic [2:0] next_pos = '0;
	byte_t      running_sum = '0;
	byte_t      payload [4];

	int unsigned frame_bytes = 0;
	int unsigned rx_count = 0;
	int unsigned fault_cnt = 0;
	int unsigned stall_cycles = 0;
	int unsigned hold_left = 0;
	logic        hold_started = 1'b0;
	logic        rx_fire = 1'b0;
	logic        quiet;

	// stretch with no idling on either side
	assign quiet = (rx_count >= 600) && (rx_count < 800);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic note_fault(input string msg);
		fault_cnt++;
		if (fault_cnt <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	// shadow of the byte-serial frame parser
	task automatic parse_byte(input byte_t b);
		field_t speed;
		field_t turn;
		wheel_t w;
		if (!in_frame) begin
			if (b == HEADER_BYTE) begin
				in_frame    = 1'b1;
				next_pos    = FIRST_POS;
				running_sum = HEADER_BYTE;
			end
		end else if (next_pos < CHECK_POS) begin
			payload[next_pos - FIRST_POS] = b;
			running_sum = running_sum + b;
			next_pos    = next_pos + 3'd1;
		end else begin
			in_frame = 1'b0;
			next_pos = '0;
			if (b == running_sum) begin
				speed   = {payload[1], payload[0]};
				turn    = {payload[3], payload[2]};
				w.speed = speed;
				w.turn  = turn;
				w.left  = target_t'(speed) + target_t'(turn);
				w.right = target_t'(turn) - target_t'(speed);
				target_q.push_back(w);
			end
			running_sum = '0;
		end
	endtask

	task automatic push_byte(input byte_t data, input logic drain);
		rx_item_t it;
		it.data  = data;
		it.drain = drain;
		byte_q.push_back(it);
	endtask

	// header, little-endian speed and turn, checksum (optionally corrupted)
	task automatic push_frame(input logic [15:0] speed, input logic [15:0] turn,
			input logic corrupt, input logic drain);
		byte_t body [4];
		byte_t sum;
		body = '{speed[7:0], speed[15:8], turn[7:0], turn[15:8]};
		sum  = HEADER_BYTE;
		foreach (body[i]) begin
			sum = sum + body[i];
		end
		if (corrupt) begin
			sum = sum + byte_t'($urandom_range(1, 255));
		end
		push_byte(HEADER_BYTE, drain);
		foreach (body[i]) begin
			push_byte(body[i], 1'b0);
		end
		push_byte(sum, 1'b0);
		frame_bytes += 6;
	endtask

	function automatic logic [15:0] pick_field();
		logic [15:0] v;
		case ($urandom_range(15))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2: v = 16'h0000;
			3: v = 16'hFFFF;
			default: v = 16'($urandom_range(16'hFFFF));
		endcase
		return v;
	endfunction

	// byte driver
	always @(negedge clk) begin
		rx_item_t nxt;
		logic     go;
		if (arst_n) begin
			if (!rx_ch.valid || rx_fire) begin
				go = (byte_q.size() != 0) && (quiet || ($urandom_range(99) >= 8));
				if (go && byte_q[0].drain && (target_q.size() != 0)) begin
					go = 1'b0;
				end
				if (go) begin
					nxt = byte_q.pop_front();
					rx_ch.rx_byte <= nxt.data;
					rx_ch.valid   <= 1'b1;
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// target receiver, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_started && (rx_count >= 400)) begin
				hold_started <= 1'b1;
				hold_left    <= HOLD_CYCLES;
				tx_ch.ready  <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left   <= hold_left - 1;
				tx_ch.ready <= 1'b0;
			end else begin
				tx_ch.ready <= quiet || ($urandom_range(99) >= 8);
			end
		end
	end

	// monitor: check targets, predict from accepted bytes, watchdog
	always @(posedge clk) begin
		wheel_t got;
		wheel_t want;
		rx_fire <= rx_ch.valid && rx_ch.ready;
		if (arst_n) begin
			if (tx_ch.valid && tx_ch.ready) begin
				got.left  = tx_ch.left_target;
				got.right = tx_ch.right_target;
				got.speed = tx_ch.forward_speed;
				got.turn  = tx_ch.turn_rate;
				if (target_q.size() == 0) begin
					note_fault($sformatf("unexpected target beat %0d/%0d/%0d/%0d",
						got.left, got.right, got.speed, got.turn));
				end else begin
					want = target_q.pop_front();
					if (got.left !== want.left)
						note_fault($sformatf("left_target expected %0d, got %0d",
							want.left, got.left));
					if (got.right !== want.right)
						note_fault($sformatf("right_target expected %0d, got %0d",
							want.right, got.right));
					if (got.speed !== want.speed)
						note_fault($sformatf("forward_speed expected %0d, got %0d",
							want.speed, got.speed));
					if (got.turn !== want.turn)
						note_fault($sformatf("turn_rate expected %0d, got %0d",
							want.turn, got.turn));
				end
			end
			if (rx_ch.valid && rx_ch.ready) begin
				rx_count++;
				parse_byte(rx_ch.rx_byte);
			end
			if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("drive_command_frame_parser_top regression: fail");
				$finish;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		byte_t       b;
		int unsigned r;
		int unsigned n;
		int unsigned frames;
		clk           = 1'b0;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		tx_ch.ready   = 1'b0;

		// directed: ignored noise, field extremes, header bytes inside a bad frame
		push_byte(8'h55, 1'b0);
		push_frame(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
		push_frame(16'h8000, 16'h8000, 1'b0, 1'b0);
		push_frame(16'h8000, 16'h7FFF, 1'b0, 1'b0);
		push_frame(16'h7FFF, 16'h8000, 1'b0, 1'b0);
		push_frame(16'hAAAA, 16'hAAAA, 1'b1, 1'b0);

		// random: mostly good frames, some bad checksums, cut frames and noise
		frames = 0;
		while (frame_bytes < FRAME_BYTE_TARGET) begin
			r = $urandom_range(99);
			if (r < 75) begin
				push_frame(pick_field(), pick_field(), 1'b0, (frames == 0) || (frames == 100));
				frames++;
			end else if (r < 87) begin
				push_frame(pick_field(), pick_field(), 1'b1, 1'b0);
			end else if (r < 93) begin
				// cut frame: the following bytes complete it
				n = $urandom_range(1, 4);
				push_byte(HEADER_BYTE, 1'b0);
				repeat (n) push_byte(byte_t'($urandom_range(255)), 1'b0);
				frame_bytes += 1 + n;
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					b = byte_t'($urandom_range(255));
					if (b == HEADER_BYTE) begin
						b = 8'h55;
					end
					push_byte(b, 1'b0);
				end
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while ((byte_q.size() != 0) || rx_ch.valid) @(posedge clk);
		while (target_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (target_q.size() != 0) begin
			note_fault($sformatf("%0d target beats never arrived", target_q.size()));
		end
		if (fault_cnt == 0) begin
			$display("drive_command_frame_parser_top regression: pass");
		end else begin
			$display("drive_command_frame_parser_top regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
